>>> hdl/clint_pkg.sv
// shared types and constants of the core-local interruptor
`default_nettype none

package clint_pkg;

  localparam int unsigned HART_IDX_W = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [15:0] MSIP_END     = 16'h4000;
  localparam logic [15:0] MTIME_ADDR   = 16'hBFF8;
  localparam logic [15:0] MAP_END      = 16'hC000;
  localparam logic [12:0] CMP_ROW_BASE = 13'h0800;

  localparam logic [CFG_IDX_W-1:0] CFG_CUR_HART = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STD_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_SET_TIME = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_NOP,
    K_SOFT_RD,
    K_SOFT_WR,
    K_CMP_RD,
    K_CMP_WR,
    K_TIME_RD,
    K_TIME_WR
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [HART_IDX_W-1:0]  hart;
    logic                   is_cur;
    logic [7:0]             lanes;
    logic [2:0]             start;
    logic [63:0]            data;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cur_hart;
    logic       std_mode;
    logic       cur_ok;
    logic       reload;
  } ctl_t;

endpackage

`default_nettype wire

>>> hdl/core_local_interruptor.sv
// top level of the core-local interruptor
//
// input channel (in_valid_i/in_ready_o): one bus read, bus write or mtime set per
// transaction; output channel (out_valid_o/out_ready_i): one result per transaction,
// in order. configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i take effect
// at once; a current_hart write reloads the compare shadow when that hart exists.
// an mtime or unmapped access passes through the queue and the result register;
// an msip or mtimecmp access also reads the per-hart register memory in between.
// throughput: one transaction per cycle for mtime and unmapped accesses while the
// result is not stalled; an msip or mtimecmp access must finish its read, and for a
// write its write, of the single-port per-hart register memory before the next one.
// a two-entry queue sits between decode and execute, and the result register
// lets the next transaction enter while a result waits.
// after reset a clearing pass over all harts presets every mtimecmp to all
// ones and every msip to zero; in_ready_o stays low until it ends.
// when out_ready_i is low the result holds and the queue fills, then in_ready_o drops.
`default_nettype none

module core_local_interruptor #(
  parameter int unsigned NUM_HARTS = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [clint_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [clint_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       op_i,
  input  wire logic [15:0]                      offset_i,
  input  wire logic [3:0]                       size_i,
  input  wire logic [63:0]                      write_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [63:0]                           read_data_o,
  output logic                                  soft_update_o,
  output logic                                  soft_pending_o,
  output logic                                  timer_update_o,
  output logic                                  timer_pending_o
);
  import clint_pkg::*;

  logic [1:0] cur_hart_q;
  logic       std_mode_q;
  ctl_t       ctl;
  cmd_t       front_cmd;
  cmd_t       queue_cmd;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;
  logic       clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_hart_q <= 2'd0;
      std_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CUR_HART: cur_hart_q <= cfg_data_i[1:0];
        CFG_STD_MODE: std_mode_q <= cfg_data_i[0];
      endcase
    end
  end

  assign ctl.cur_hart = cur_hart_q;
  assign ctl.std_mode = std_mode_q;
  assign ctl.cur_ok   = HART_IDX_W'(cur_hart_q) < HART_IDX_W'(NUM_HARTS);
  assign ctl.reload   = cfg_we_i && (cfg_idx_i == CFG_CUR_HART);

  clint_front #(
    .NUM_HARTS (NUM_HARTS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .offset_i     (offset_i),
    .size_i       (size_i),
    .write_data_i (write_data_i),
    .cur_hart_i   (cur_hart_q),
    .queue_full_i (queue_full),
    .block_i      (clearing || cfg_we_i),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  clint_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .pop_i   (pop),
    .data_o  (queue_cmd),
    .full_o  (queue_full),
    .empty_o (queue_empty)
  );

  clint_back #(
    .NUM_HARTS (NUM_HARTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .cmd_i           (queue_cmd),
    .cmd_valid_i     (!queue_empty),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .soft_update_o   (soft_update_o),
    .soft_pending_o  (soft_pending_o),
    .timer_update_o  (timer_update_o),
    .timer_pending_o (timer_pending_o)
  );

endmodule

`default_nettype wire

>>> hdl/clint_front.sv
// request decode: classifies each access and aligns its write bytes
`default_nettype none

module clint_front #(
  parameter int unsigned NUM_HARTS = 4
) (
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            op_i,
  input  wire logic [15:0]           offset_i,
  input  wire logic [3:0]            size_i,
  input  wire logic [63:0]           write_data_i,
  input  wire logic [1:0]            cur_hart_i,
  input  wire logic                  queue_full_i,
  input  wire logic                  block_i,
  output logic                       push_o,
  output clint_pkg::cmd_t            cmd_o
);
  import clint_pkg::*;

  assign in_ready_o = !queue_full_i && !block_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    logic [12:0]           cmp_row;
    logic [HART_IDX_W-1:0] hart;
    logic [2:0]            start;
    logic [3:0]            reg_bytes;
    logic                  in_range;
    logic                  mapped;
    logic [7:0]            lanes;
    kind_e                 rd_kind;
    kind_e                 wr_kind;

    cmp_row   = offset_i[15:3] - CMP_ROW_BASE;
    hart      = '0;
    start     = offset_i[2:0];
    reg_bytes = 4'd8;
    in_range  = 1'b1;
    mapped    = 1'b1;
    rd_kind   = K_NOP;
    wr_kind   = K_NOP;

    if (offset_i < MSIP_END) begin
      hart      = offset_i[13:2];
      start     = {1'b0, offset_i[1:0]};
      reg_bytes = 4'd4;
      in_range  = hart < HART_IDX_W'(NUM_HARTS);
      rd_kind   = K_SOFT_RD;
      wr_kind   = K_SOFT_WR;
    end else if (offset_i < MTIME_ADDR) begin
      hart      = cmp_row[HART_IDX_W-1:0];
      in_range  = hart < HART_IDX_W'(NUM_HARTS);
      rd_kind   = K_CMP_RD;
      wr_kind   = K_CMP_WR;
    end else if (offset_i < MAP_END) begin
      rd_kind   = K_TIME_RD;
      wr_kind   = K_TIME_WR;
    end else begin
      mapped    = 1'b0;
    end

    for (int i = 0; i < 8; i++) begin
      lanes[i] = (3'(i) >= start) && (4'(i) < reg_bytes)
                 && ((4'(i) - {1'b0, start}) < size_i);
    end

    cmd_o.kind = K_NOP;
    unique case (op_e'(op_i))
      OP_READ: begin
        if (mapped && in_range) begin
          cmd_o.kind = rd_kind;
        end
      end
      OP_WRITE: begin
        if (mapped && in_range) begin
          cmd_o.kind = wr_kind;
        end
      end
      OP_SET_TIME: begin
        cmd_o.kind = K_TIME_WR;
        lanes      = 8'hFF;
        start      = 3'd0;
      end
      OP_NONE: begin
        cmd_o.kind = K_NOP;
      end
    endcase

    cmd_o.hart   = hart;
    cmd_o.is_cur = hart == HART_IDX_W'(cur_hart_i);
    cmd_o.lanes  = lanes;
    cmd_o.start  = start;
    cmd_o.data   = write_data_i << {start, 3'b000};
  end

endmodule

`default_nettype wire

>>> hdl/clint_queue.sv
// two-entry command queue between decode and execute
`default_nettype none

module clint_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire clint_pkg::cmd_t data_i,
  input  wire logic            pop_i,
  output clint_pkg::cmd_t      data_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import clint_pkg::*;

  cmd_t       entries_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hdl/clint_back.sv
// execute unit: register file, mtime, compare shadow and result register
`default_nettype none

module clint_back #(
  parameter int unsigned NUM_HARTS = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire clint_pkg::ctl_t ctl_i,
  input  wire clint_pkg::cmd_t cmd_i,
  input  wire logic            cmd_valid_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [63:0]          read_data_o,
  output logic                 soft_update_o,
  output logic                 soft_pending_o,
  output logic                 timer_update_o,
  output logic                 timer_pending_o
);
  import clint_pkg::*;

  localparam int unsigned HART_W = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
  localparam logic [HART_W-1:0] LAST_HART = HART_W'(NUM_HARTS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_RELOAD
  } state_e;

  function automatic logic [63:0] lane_bits(input logic [7:0] lanes);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = {8{lanes[i]}};
    end
    return m;
  endfunction

  function automatic logic is_mem(input kind_e kind);
    return (kind == K_SOFT_RD) || (kind == K_SOFT_WR)
           || (kind == K_CMP_RD) || (kind == K_CMP_WR);
  endfunction

  // bit 64 holds msip, bits 63:0 hold mtimecmp
  logic [64:0]       regs_q [NUM_HARTS];
  logic [64:0]       rdata_q;

  state_e            state_q, state_d;
  logic [HART_W-1:0] clr_idx_q, clr_idx_d;
  logic              reload_q, reload_d;
  logic [63:0]       time_q, time_d;
  logic [63:0]       shadow_q, shadow_d;
  cmd_t              acc_q, acc_d;
  logic              out_valid_q;
  logic [63:0]       read_data_q;
  logic              soft_update_q, soft_pending_q;
  logic              timer_update_q, timer_pending_q;

  logic              mem_re, mem_we;
  logic [HART_W-1:0] mem_raddr, mem_waddr;
  logic [64:0]       mem_wdata;
  logic              load;
  logic [63:0]       res_rd;
  logic              res_su, res_sp, res_tu, res_tp;
  logic              out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign clearing_o = state_q == ST_CLEAR;

  always_comb begin
    logic [63:0] m_cmd;
    logic [63:0] m_acc;
    logic [63:0] time_new;
    logic [63:0] cmp_new;
    logic        soft_new;

    m_cmd    = lane_bits(cmd_i.lanes);
    m_acc    = lane_bits(acc_q.lanes);
    time_new = (time_q & ~m_cmd) | (cmd_i.data & m_cmd);
    cmp_new  = (rdata_q[63:0] & ~m_acc) | (acc_q.data & m_acc);
    soft_new = acc_q.lanes[0] ? acc_q.data[0] : rdata_q[64];

    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    reload_d  = reload_q || ctl_i.reload;
    time_d    = time_q;
    shadow_d  = shadow_q;
    acc_d     = acc_q;
    pop_o     = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = cmd_i.hart[HART_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = acc_q.hart[HART_W-1:0];
    mem_wdata = rdata_q;
    load      = 1'b0;
    res_rd    = '0;
    res_su    = 1'b0;
    res_sp    = 1'b0;
    res_tu    = 1'b0;
    res_tp    = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = {1'b0, {64{1'b1}}};
        if (clr_idx_q == LAST_HART) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (reload_q) begin
          if (ctl_i.cur_ok) begin
            mem_re    = 1'b1;
            mem_raddr = HART_W'(ctl_i.cur_hart);
            state_d   = ST_RELOAD;
          end else begin
            reload_d = ctl_i.reload;
          end
        end else if (cmd_valid_i) begin
          if (is_mem(cmd_i.kind)) begin
            pop_o   = 1'b1;
            mem_re  = 1'b1;
            acc_d   = cmd_i;
            state_d = ST_ACCESS;
          end else if (out_free) begin
            pop_o = 1'b1;
            load  = 1'b1;
            unique case (cmd_i.kind)
              K_TIME_RD: begin
                res_rd = (time_q & m_cmd) >> {cmd_i.start, 3'b000};
              end
              K_TIME_WR: begin
                time_d = time_new;
                res_tu = ctl_i.cur_ok;
                res_tp = ctl_i.cur_ok && (time_new >= shadow_q);
              end
              default: begin
                res_rd = '0;
              end
            endcase
          end
        end
      end
      ST_ACCESS: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
          unique case (acc_q.kind)
            K_SOFT_RD: begin
              res_rd = {63'd0, acc_q.lanes[0] && rdata_q[64]};
            end
            K_SOFT_WR: begin
              mem_we    = 1'b1;
              mem_wdata = {soft_new, rdata_q[63:0]};
              res_su    = acc_q.is_cur;
              res_sp    = acc_q.is_cur && soft_new;
            end
            K_CMP_RD: begin
              res_rd = (rdata_q[63:0] & m_acc) >> {acc_q.start, 3'b000};
            end
            K_CMP_WR: begin
              mem_we    = 1'b1;
              mem_wdata = {rdata_q[64], cmp_new};
              if (acc_q.is_cur) begin
                shadow_d = cmp_new;
                res_tu   = 1'b1;
                res_tp   = ctl_i.std_mode && (time_q >= cmp_new);
              end
            end
            default: begin
              res_rd = '0;
            end
          endcase
        end
      end
      ST_RELOAD: begin
        shadow_d = rdata_q[63:0];
        reload_d = ctl_i.reload;
        state_d  = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      regs_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= regs_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_idx_q       <= '0;
      reload_q        <= 1'b0;
      time_q          <= '0;
      shadow_q        <= '1;
      out_valid_q     <= 1'b0;
      read_data_q     <= '0;
      soft_update_q   <= 1'b0;
      soft_pending_q  <= 1'b0;
      timer_update_q  <= 1'b0;
      timer_pending_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      reload_q    <= reload_d;
      time_q      <= time_d;
      shadow_q    <= shadow_d;
      out_valid_q <= load || (out_valid_q && !out_ready_i);
      if (load) begin
        read_data_q     <= res_rd;
        soft_update_q   <= res_su;
        soft_pending_q  <= res_sp;
        timer_update_q  <= res_tu;
        timer_pending_q <= res_tp;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = read_data_q;
  assign soft_update_o   = soft_update_q;
  assign soft_pending_o  = soft_pending_q;
  assign timer_update_o  = timer_update_q;
  assign timer_pending_o = timer_pending_q;

  a_access_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCESS && out_valid_q && !out_ready_i) |=> state_q == ST_ACCESS)
    else $error("register access left while result slot busy");

  a_reload_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RELOAD |-> $past(state_q) == ST_IDLE && $past(reload_q))
    else $error("shadow reload without request");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_idx_q == LAST_HART) |=> state_q == ST_IDLE)
    else $error("clearing pass did not finish");

endmodule

`default_nettype wire
